FILE: sv/urb_pkg.sv
// Shared types and constants for the UART receive ring buffer.
package urb_pkg;

  // Operation codes carried in the func field
  typedef enum logic [2:0] {
    FUNC_RX     = 3'd0,
    FUNC_POP    = 3'd1,
    FUNC_STATUS = 3'd2,
    FUNC_RESET  = 3'd3,
    FUNC_TICK   = 3'd4
  } func_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RING_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TIMEOUT = 2'd1;

  // Sticky error bit positions
  localparam int unsigned ERR_FRAME    = 0;
  localparam int unsigned ERR_OVERRUN  = 1;
  localparam int unsigned ERR_OVERFLOW = 2;
  localparam int unsigned ERR_W        = 3;

  // Defaults
  localparam int unsigned RING_DEPTH_DEF    = 256;
  localparam logic [7:0]  RING_SIZE_RST     = 8'd64;
  localparam logic [7:0]  GAP_TIMEOUT_RST   = 8'd6;

endpackage

FILE: sv/uart_rx_ring_buffer_top.sv
// Top level of the UART receive ring buffer: ring store, pointers, flags and gap timer.
//
//   channel   direction  handshake              payload
//   in        sink       in_valid / in_stall    func, rx_byte, frame_error, overrun_error
//   out       source     out_valid / out_stall  read_data, read_valid, byte_ready,
//                                               bytes_available, head_byte, frame_seen,
//                                               overrun_seen, overflow_seen, gap_timeout
//   cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One transaction per clock while in_stall is low; its result appears in the cycle after acceptance, the
// latency being set by the registered read of the ring store.
// The output register holds one result; in_stall is high only while that result is
// waiting and out_stall is high, so a new transaction is taken as the old one leaves.
// Synchronous reset clears pointers, flags, timer and output valid; the ring store has
// no reset and needs no clearing pass, so transactions are accepted right after reset.
module uart_rx_ring_buffer_top #(
  parameter int unsigned RING_DEPTH = urb_pkg::RING_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // input transaction channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   func,
  input  logic [7:0]                   rx_byte,
  input  logic                         frame_error,
  input  logic                         overrun_error,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   read_data,
  output logic                         read_valid,
  output logic                         byte_ready,
  output logic [7:0]                   bytes_available,
  output logic [7:0]                   head_byte,
  output logic                         frame_seen,
  output logic                         overrun_seen,
  output logic                         overflow_seen,
  output logic                         gap_timeout,
  // configuration write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [urb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                   cfg_data
);

  localparam int unsigned PW = $clog2(RING_DEPTH);
  localparam int unsigned SW = PW + 1;

  // Clamp a ring size write to the range 2 .. RING_DEPTH
  function automatic logic [SW-1:0] clamp_size(input logic [7:0] v);
    logic [8:0] v9;
    logic [8:0] r;
    v9 = {1'b0, v};
    if (v9 < 9'd2) begin
      r = 9'd2;
    end else if (v9 > 9'(RING_DEPTH)) begin
      r = 9'(RING_DEPTH);
    end else begin
      r = v9;
    end
    return SW'(r);
  endfunction

  // Pointer increment with wrap at the effective size
  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p,
                                            input logic [SW-1:0] sz);
    logic [SW-1:0] n;
    n = {1'b0, p} + SW'(1);
    if (n >= sz) begin
      return '0;
    end
    return n[PW-1:0];
  endfunction

  // Architectural state
  logic [7:0]              ring_mem [RING_DEPTH];
  logic [PW-1:0]           wp;
  logic [PW-1:0]           rp;
  logic [urb_pkg::ERR_W-1:0] err;
  logic [7:0]              timer;
  logic [SW-1:0]           size_eff;
  logic [7:0]              gap_ticks;

  // Result register contents not driven straight to ports
  logic [7:0]              pop_data;
  logic [7:0]              head_mem;
  logic                    head_byp;
  logic [7:0]              byp_data;

  // Next-state values
  logic [PW-1:0]           wp_next;
  logic [PW-1:0]           rp_next;
  logic [urb_pkg::ERR_W-1:0] err_next;
  logic [urb_pkg::ERR_W-1:0] shown;
  logic [7:0]              timer_next;
  logic                    pop_valid;
  logic [PW-1:0]           wp_adv;
  logic [SW-1:0]           avail;
  logic                    byp;
  logic                    accept;
  logic                    is_rx;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign is_rx     = (func == urb_pkg::FUNC_RX);
  assign wp_adv    = advance(wp, size_eff);

  // Transaction decode and state update
  always_comb begin
    wp_next    = wp;
    rp_next    = rp;
    err_next   = err;
    timer_next = timer;
    pop_valid  = 1'b0;
    case (func)
      urb_pkg::FUNC_RX: begin
        if (frame_error) err_next[urb_pkg::ERR_FRAME] = 1'b1;
        if (overrun_error) err_next[urb_pkg::ERR_OVERRUN] = 1'b1;
        timer_next = gap_ticks;
        wp_next    = wp_adv;
        if (wp_adv == rp) err_next[urb_pkg::ERR_OVERFLOW] = 1'b1;
      end
      urb_pkg::FUNC_POP: begin
        if (rp != wp) begin
          pop_valid = 1'b1;
          rp_next   = advance(rp, size_eff);
        end
      end
      urb_pkg::FUNC_TICK: begin
        if (timer != 8'd0) timer_next = timer - 8'd1;
      end
      default: ;
    endcase
    shown = err_next;
    case (func)
      urb_pkg::FUNC_STATUS: begin
        err_next = '0;
      end
      urb_pkg::FUNC_RESET: begin
        wp_next  = '0;
        rp_next  = '0;
        err_next = '0;
      end
      default: ;
    endcase
  end

  // Fill level and same-cycle head bypass
  always_comb begin
    if (wp_next >= rp_next) begin
      avail = {1'b0, wp_next} - {1'b0, rp_next};
    end else begin
      avail = size_eff - {1'b0, rp_next} + {1'b0, wp_next};
    end
    byp = is_rx & (rp_next == wp);
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      rp        <= '0;
      err       <= '0;
      timer     <= 8'd0;
      size_eff  <= clamp_size(urb_pkg::RING_SIZE_RST);
      gap_ticks <= urb_pkg::GAP_TIMEOUT_RST;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        wp    <= wp_next;
        rp    <= rp_next;
        err   <= err_next;
        timer <= timer_next;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          urb_pkg::REG_RING_SIZE: begin
            size_eff <= clamp_size(cfg_data);
            wp       <= '0;
            rp       <= '0;
            err      <= '0;
          end
          urb_pkg::REG_GAP_TIMEOUT: begin
            gap_ticks <= cfg_data;
          end
          default: ;
        endcase
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Ring store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (accept && is_rx) begin
      ring_mem[wp] <= rx_byte;
    end
    if (accept) begin
      pop_data <= ring_mem[rp];
      head_mem <= ring_mem[rp_next];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (accept) begin
      read_valid      <= pop_valid;
      byte_ready      <= (rp_next != wp_next);
      bytes_available <= 8'(avail);
      head_byp        <= byp;
      byp_data        <= rx_byte;
      frame_seen      <= shown[urb_pkg::ERR_FRAME];
      overrun_seen    <= shown[urb_pkg::ERR_OVERRUN];
      overflow_seen   <= shown[urb_pkg::ERR_OVERFLOW];
      gap_timeout     <= (timer_next == 8'd0);
    end
  end

  // Zero the data fields when there is nothing to show
  assign read_data = read_valid ? pop_data : 8'd0;
  assign head_byte = byte_ready ? (head_byp ? byp_data : head_mem) : 8'd0;

`ifndef SYNTHESIS
  // An accepted transaction always leaves a result behind it
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted transaction produced no result");

  // Ready flag and fill level agree
  a_ready_level: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_ready == (bytes_available != 8'd0)))
    else $error("byte_ready disagrees with bytes_available");

  // Pointers stay inside the ring in use
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, wp} < size_eff) && ({1'b0, rp} < size_eff))
    else $error("ring pointer beyond effective size");

  // A pop only returns a byte when the ring held one
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (accept && pop_valid) |-> (wp != rp))
    else $error("pop from an empty ring");
`endif

endmodule

FILE: sim/urb_checker.sv
// Checker for the UART receive ring buffer: follows the channels, predicts and compares results.
module urb_checker #(
  parameter int unsigned RING_DEPTH = urb_pkg::RING_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [2:0]                    func,
  input  logic [7:0]                    rx_byte,
  input  logic                          frame_error,
  input  logic                          overrun_error,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [7:0]                    read_data,
  input  logic                          read_valid,
  input  logic                          byte_ready,
  input  logic [7:0]                    bytes_available,
  input  logic [7:0]                    head_byte,
  input  logic                          frame_seen,
  input  logic                          overrun_seen,
  input  logic                          overflow_seen,
  input  logic                          gap_timeout,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [urb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  output int                            pending,
  output int                            fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
    logic       byte_ready;
    logic [7:0] bytes_available;
    logic [7:0] head_byte;
    logic       frame_seen;
    logic       overrun_seen;
    logic       overflow_seen;
    logic       gap_timeout;
  } ring_result_t;

  // Own copy of the ring state and its registers
  logic [7:0]                ring_copy [RING_DEPTH];
  int unsigned               wr_slot;
  int unsigned               rd_slot;
  int unsigned               gap_left;
  logic [urb_pkg::ERR_W-1:0] sticky;
  logic [7:0]                size_reg;
  logic [7:0]                gap_reg;

  ring_result_t ring_results_q [$];
  ring_result_t want;
  int           fails = 0;

  initial begin
    pending    = 0;
    fail_count = 0;
  end

  // Ring size in use, clamped to what the store holds
  function automatic int unsigned ring_span();
    if (size_reg < 2) return 2;
    if (size_reg > RING_DEPTH) return RING_DEPTH;
    return size_reg;
  endfunction

  function automatic int unsigned next_slot(input int unsigned p);
    int unsigned n;
    n = p + 1;
    if (n >= ring_span()) n = 0;
    return n;
  endfunction

  // One operation on the ring; returns the status it reports
  function automatic ring_result_t ring_step(input logic [2:0] op, input logic [7:0] data,
                                             input logic fe, input logic oe);
    ring_result_t              r;
    logic [urb_pkg::ERR_W-1:0] shown;
    r = '0;
    case (op)
      urb_pkg::FUNC_RX: begin
        if (fe) sticky[urb_pkg::ERR_FRAME] = 1'b1;
        if (oe) sticky[urb_pkg::ERR_OVERRUN] = 1'b1;
        ring_copy[wr_slot] = data;
        gap_left = gap_reg;
        wr_slot = next_slot(wr_slot);
        // writer caught the reader: ring looks empty, contents lost
        if (wr_slot == rd_slot) sticky[urb_pkg::ERR_OVERFLOW] = 1'b1;
      end
      urb_pkg::FUNC_POP: begin
        if (rd_slot != wr_slot) begin
          r.read_data  = ring_copy[rd_slot];
          r.read_valid = 1'b1;
          rd_slot = next_slot(rd_slot);
        end
      end
      urb_pkg::FUNC_TICK: begin
        if (gap_left > 0) gap_left--;
      end
      default: ;
    endcase

    // flags are reported before a status read or reset clears them
    shown = sticky;
    if (op == urb_pkg::FUNC_STATUS) begin
      sticky = '0;
    end else if (op == urb_pkg::FUNC_RESET) begin
      wr_slot = 0;
      rd_slot = 0;
      sticky  = '0;
    end

    r.byte_ready      = (rd_slot != wr_slot);
    r.bytes_available = (wr_slot >= rd_slot) ? 8'(wr_slot - rd_slot)
                                             : 8'(ring_span() - rd_slot + wr_slot);
    r.head_byte       = r.byte_ready ? ring_copy[rd_slot] : 8'h00;
    r.frame_seen      = shown[urb_pkg::ERR_FRAME];
    r.overrun_seen    = shown[urb_pkg::ERR_OVERRUN];
    r.overflow_seen   = shown[urb_pkg::ERR_OVERFLOW];
    r.gap_timeout     = (gap_left == 0);
    return r;
  endfunction

  task automatic compare_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
    if (exp_val != act_val) begin
      fails++;
      if (fails <= 10)
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
    end
  endtask

  // Sample all three channels at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      ring_results_q.delete();
      wr_slot  = 0;
      rd_slot  = 0;
      gap_left = 0;
      sticky   = '0;
      size_reg = urb_pkg::RING_SIZE_RST;
      gap_reg  = urb_pkg::GAP_TIMEOUT_RST;
    end else begin
      // result transaction
      if (out_valid && !out_stall) begin
        if (ring_results_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("%0t ns: result with none outstanding", $time);
        end else begin
          want = ring_results_q.pop_front();
          compare_field("read_data",       want.read_data,       read_data);
          compare_field("read_valid",      want.read_valid,      read_valid);
          compare_field("byte_ready",      want.byte_ready,      byte_ready);
          compare_field("bytes_available", want.bytes_available, bytes_available);
          compare_field("head_byte",       want.head_byte,       head_byte);
          compare_field("frame_seen",      want.frame_seen,      frame_seen);
          compare_field("overrun_seen",    want.overrun_seen,    overrun_seen);
          compare_field("overflow_seen",   want.overflow_seen,   overflow_seen);
          compare_field("gap_timeout",     want.gap_timeout,     gap_timeout);
        end
      end

      // register write; a size change also empties the ring
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == urb_pkg::REG_RING_SIZE) begin
          size_reg = cfg_data;
          wr_slot  = 0;
          rd_slot  = 0;
          sticky   = '0;
        end else if (cfg_index == urb_pkg::REG_GAP_TIMEOUT) begin
          gap_reg = cfg_data;
        end
      end

      // input transaction
      if (in_valid && !in_stall)
        ring_results_q.push_back(ring_step(func, rx_byte, frame_error, overrun_error));
    end
    pending    <= ring_results_q.size();
    fail_count <= fails;
  end

endmodule

FILE: sim/testbench.sv
// Testbench top for the UART receive ring buffer: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Indexes past the register list, and the unused operation codes
  localparam logic [urb_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [urb_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
  localparam logic [2:0] FUNC_SPARE_MID   = 3'd6;
  localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [2:0]                    func = urb_pkg::FUNC_TICK;
  logic [7:0]                    rx_byte = 8'h00;
  logic                          frame_error = 1'b0;
  logic                          overrun_error = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [7:0]                    read_data;
  logic                          read_valid;
  logic                          byte_ready;
  logic [7:0]                    bytes_available;
  logic [7:0]                    head_byte;
  logic                          frame_seen;
  logic                          overrun_seen;
  logic                          overflow_seen;
  logic                          gap_timeout;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [urb_pkg::CFG_IDX_W-1:0] cfg_index = urb_pkg::REG_RING_SIZE;
  logic [7:0]                    cfg_data = 8'h00;
  int                            pending;
  int                            fail_count;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  uart_rx_ring_buffer_top uut (.*);
  urb_checker             chk (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver back-pressure
  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  // Run limit
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  // Present one transaction, with a random gap first; valid stays high afterwards
  task automatic send_item(input logic [2:0] op, input logic [7:0] data,
                           input logic fe, input logic oe);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid      <= 1'b1;
    func          <= op;
    rx_byte       <= data;
    frame_error   <= fe;
    overrun_error <= oe;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending until every outstanding result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [urb_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_ring(input logic [7:0] size_val, input logic [7:0] gap_val);
    write_reg(urb_pkg::REG_RING_SIZE, size_val);
    write_reg(urb_pkg::REG_GAP_TIMEOUT, gap_val);
    cfg_valid <= 1'b0;
  endtask

  // Mostly received bytes and pops, some ticks and status reads, little else
  task automatic random_item(input int rx_pct);
    logic [2:0]  op;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < rx_pct) begin
      op = urb_pkg::FUNC_RX;
    end else begin
      pick = $urandom_range(99);
      if (pick < 55)      op = urb_pkg::FUNC_POP;
      else if (pick < 78) op = urb_pkg::FUNC_TICK;
      else if (pick < 90) op = urb_pkg::FUNC_STATUS;
      else if (pick < 95) op = urb_pkg::FUNC_RESET;
      else                op = 3'($urandom_range(FUNC_SPARE_LAST, FUNC_SPARE_FIRST));
    end
    send_item(op, 8'($urandom_range(255)), $urandom_range(15) == 0, $urandom_range(15) == 0);
  endtask

  initial begin
    int         rx_pct;
    logic [7:0] size_val;
    logic [7:0] gap_val;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    set_idle(31, 75);

    // Directed: reset registers, empty ring, flags and unused codes
    send_item(urb_pkg::FUNC_STATUS, 8'h00, 1'b0, 1'b0);
    send_item(urb_pkg::FUNC_POP,    8'h00, 1'b0, 1'b0);
    send_item(urb_pkg::FUNC_TICK,   8'h00, 1'b0, 1'b0);
    send_item(urb_pkg::FUNC_RX,     8'h00, 1'b1, 1'b0);
    send_item(urb_pkg::FUNC_RX,     8'hFF, 1'b0, 1'b1);
    send_item(urb_pkg::FUNC_TICK,   8'h00, 1'b0, 1'b0);
    send_item(urb_pkg::FUNC_STATUS, 8'h00, 1'b0, 1'b0);
    send_item(urb_pkg::FUNC_STATUS, 8'h00, 1'b0, 1'b0);
    send_item(urb_pkg::FUNC_POP,    8'h00, 1'b0, 1'b0);
    send_item(urb_pkg::FUNC_POP,    8'h00, 1'b0, 1'b0);
    send_item(urb_pkg::FUNC_POP,    8'h00, 1'b0, 1'b0);
    send_item(urb_pkg::FUNC_RX,     8'hA5, 1'b1, 1'b1);
    send_item(urb_pkg::FUNC_RESET,  8'h00, 1'b0, 1'b0);
    send_item(FUNC_SPARE_FIRST,     8'hFF, 1'b1, 1'b1);
    send_item(FUNC_SPARE_MID,       8'h00, 1'b0, 1'b0);
    send_item(FUNC_SPARE_LAST,      8'h3C, 1'b0, 1'b0);

    // Size below the minimum clamps to two; zero timeout keeps the flag up
    drain();
    set_ring(8'd0, 8'd0);
    send_item(urb_pkg::FUNC_RX,     8'h5A, 1'b0, 1'b0);
    send_item(urb_pkg::FUNC_RX,     8'hC3, 1'b0, 1'b0);
    send_item(urb_pkg::FUNC_STATUS, 8'h00, 1'b0, 1'b0);
    send_item(urb_pkg::FUNC_RESET,  8'h00, 1'b0, 1'b0);

    // Size one, longest timeout; reset reports every sticky bit
    drain();
    set_ring(8'd1, 8'd255);
    send_item(urb_pkg::FUNC_RX,     8'h81, 1'b1, 1'b1);
    send_item(urb_pkg::FUNC_RX,     8'h7E, 1'b0, 1'b0);
    send_item(urb_pkg::FUNC_RESET,  8'h00, 1'b0, 1'b0);

    // Writes past the register list are ignored
    drain();
    write_reg(REG_SPARE_LO, 8'hFF);
    write_reg(REG_SPARE_HI, 8'h00);
    cfg_valid <= 1'b0;
    send_item(urb_pkg::FUNC_TICK,   8'h00, 1'b0, 1'b0);

    // Random part: six phases over three idling regimes
    for (int blk = 0; blk < 6; blk++) begin
      drain();
      case (blk)
        0: begin size_val = 8'd3;   gap_val = 8'd1;   end
        1: begin size_val = 8'd255; gap_val = 8'd255; end
        2: begin size_val = 8'd2;   gap_val = 8'd0;   end
        3: begin size_val = 8'd16;  gap_val = 8'd6;   end
        4: begin size_val = 8'd1;   gap_val = 8'd2;   end
        default: begin
          size_val = 8'($urandom_range(40, 2));
          gap_val  = 8'($urandom_range(255));
        end
      endcase
      set_ring(size_val, gap_val);
      if (blk < 2)      set_idle(31, 75);
      else if (blk < 4) set_idle(75, 31);
      else              set_idle(0, 0);
      rx_pct = $urandom_range(60, 30);
      for (int k = 0; k < 190; k++) begin
        random_item(rx_pct);
        if ($urandom_range(199) == 0) drain();
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/urb_pkg.sv
sv/uart_rx_ring_buffer_top.sv
sim/urb_checker.sv
sim/testbench.sv
